/* sv/c2d_pkg.sv */
// c2d_pkg: shared constants, codes and control/status structs for the 2x2 convolution block.
// Used by c2d_ctrl, c2d_dp and conv2d_2x2_multichannel. No dependencies.
package c2d_pkg;

  // Store dimensions
  localparam int MAX_ROWS     = 16;
  localparam int MAX_COLS     = 16;
  localparam int MAX_CHANNELS = 8;
  localparam int MAX_FILTERS  = 8;
  localparam int KTAPS        = 4;

  // Field widths of one input word
  localparam int CMD_W    = 2;
  localparam int ROW_W    = 4;
  localparam int COL_W    = 4;
  localparam int CH_W     = 3;
  localparam int FILTER_W = 3;
  localparam int TAP_W    = 2;
  localparam int VALUE_W  = 16;
  localparam int SUM_W    = 32;

  // Configuration register widths
  localparam int DIM_CFG_W = 5;   // input_rows, input_cols
  localparam int CNT_CFG_W = 4;   // input_channels, filter_count
  localparam int CFG_DATA_W = 5;
  localparam int CFG_IDX_W  = 2;

  // Store geometry
  localparam int WMEM_DEPTH = MAX_FILTERS * MAX_CHANNELS * KTAPS;
  localparam int AMEM_DEPTH = MAX_ROWS * MAX_COLS * MAX_CHANNELS;
  localparam int WADDR_W    = FILTER_W + CH_W + TAP_W;
  localparam int AADDR_W    = ROW_W + COL_W + CH_W;

  // Accumulator: 32-bit products, up to MAX_CHANNELS*KTAPS of them
  localparam int PROD_W = 2 * VALUE_W;
  localparam int ACC_W  = PROD_W + $clog2(MAX_CHANNELS * KTAPS) + 1;
  localparam int FRAC_SHIFT = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_WEIGHT = 2'd0,
    CMD_WR_ACT    = 2'd1,
    CMD_QUERY     = 2'd2
  } cmd_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS  = 2'd0,
    REG_COLS  = 2'd1,
    REG_CHANS = 2'd2,
    REG_FILTS = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ISSUE,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_FINISH
  } c2d_state_t;

  // Controller to datapath
  typedef struct packed {
    logic              capture;    // latch query position and filter, clear accumulator
    logic              wr_weight;  // store value into weight memory
    logic              wr_act;     // store value into activation memory
    logic              issue;      // read one channel/tap pair
    logic [CH_W-1:0]   ch;
    logic [TAP_W-1:0]  tap;
    logic              out_load;   // load result registers, raise done
  } c2d_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic                 range_err;
    logic [CNT_CFG_W-1:0] chans;
  } c2d_stat_t;

endpackage

/* sv/c2d_ctrl.sv */
// c2d_ctrl: sequencer for the 2x2 convolution block; walks channels and taps of one query.
// Depends on c2d_pkg.
module c2d_ctrl
  import c2d_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [CMD_W-1:0] command,
  input  c2d_stat_t        stat,
  output c2d_cmd_t         cmd,
  output logic             busy
);

  c2d_state_t state, state_next;
  logic [CH_W-1:0]  ch, ch_next;
  logic [TAP_W-1:0] tap, tap_next;
  logic             accept;
  logic             last_ch;

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign last_ch = ((CNT_CFG_W'(ch) + CNT_CFG_W'(1)) == stat.chans);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ch    <= '0;
      tap   <= '0;
    end else begin
      state <= state_next;
      ch    <= ch_next;
      tap   <= tap_next;
    end
  end

  always_comb begin
    state_next    = state;
    ch_next       = ch;
    tap_next      = tap;
    cmd.capture   = 1'b0;
    cmd.wr_weight = 1'b0;
    cmd.wr_act    = 1'b0;
    cmd.issue     = 1'b0;
    cmd.ch        = ch;
    cmd.tap       = tap;
    cmd.out_load  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.wr_weight = (command == CMD_WR_WEIGHT);
          cmd.wr_act    = (command == CMD_WR_ACT);
          if (command == CMD_QUERY) begin
            cmd.capture = 1'b1;
            state_next  = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        ch_next  = '0;
        tap_next = '0;
        priority if (stat.range_err) begin
          state_next = ST_FINISH;
        end else if (stat.chans == '0) begin
          state_next = ST_DRAIN1;
        end else begin
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
        tap_next  = tap + TAP_W'(1);
        if (tap == TAP_W'(KTAPS - 1)) begin
          ch_next = ch + CH_W'(1);
          if (last_ch) begin
            state_next = ST_DRAIN1;
          end
        end
      end
      ST_DRAIN1: state_next = ST_DRAIN2;
      ST_DRAIN2: state_next = ST_FINISH;
      ST_FINISH: begin
        cmd.out_load = 1'b1;
        state_next   = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_issue_within_chans: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> (CNT_CFG_W'(ch) < stat.chans))
    else $error("c2d_ctrl: read issued beyond active channel count");

  a_query_enters_check: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (state == ST_CHECK))
    else $error("c2d_ctrl: captured query did not enter range check");

  a_finish_after_check_or_drain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) |-> ($past(state) == ST_DRAIN2 || $past(state) == ST_CHECK))
    else $error("c2d_ctrl: result loaded without drain or range error");

endmodule

/* sv/c2d_dp.sv */
// c2d_dp: datapath of the 2x2 convolution block: config registers, weight and activation
// memories, multiply-accumulate pipeline and result registers. Depends on c2d_pkg.
module c2d_dp
  import c2d_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  c2d_cmd_t                   cmd,
  output c2d_stat_t                  stat,
  input  logic [ROW_W-1:0]           row,
  input  logic [COL_W-1:0]           col,
  input  logic [CH_W-1:0]            channel,
  input  logic [FILTER_W-1:0]        filter,
  input  logic [TAP_W-1:0]           tap,
  input  logic signed [VALUE_W-1:0]  value,
  input  logic                       write_enable,
  input  logic [CFG_IDX_W-1:0]       reg_index,
  input  logic [CFG_DATA_W-1:0]      write_data,
  output logic signed [SUM_W-1:0]    sum,
  output logic                       out_of_range,
  output logic                       done
);

  localparam logic signed [ACC_W-1:0] SAT_MAX =
    {{(ACC_W-SUM_W+1){1'b0}}, {(SUM_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN =
    {{(ACC_W-SUM_W+1){1'b1}}, {(SUM_W-1){1'b0}}};

  // configuration
  logic [DIM_CFG_W-1:0] rows_reg, cols_reg, rows_eff, cols_eff;
  logic [CNT_CFG_W-1:0] chans_reg, filts_reg, chans_eff, filts_eff;

  // latched query
  logic [ROW_W-1:0]    q_row;
  logic [COL_W-1:0]    q_col;
  logic [FILTER_W-1:0] q_filter;

  // memories
  logic [VALUE_W-1:0] wmem [WMEM_DEPTH];
  logic [VALUE_W-1:0] amem [AMEM_DEPTH];
  logic [WADDR_W-1:0] w_wr_addr, w_rd_addr;
  logic [AADDR_W-1:0] a_wr_addr, a_rd_addr;
  logic [ROW_W-1:0]   rd_row;
  logic [COL_W-1:0]   rd_col;

  // MAC pipeline
  logic signed [VALUE_W-1:0] rd_w, rd_a;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc, shifted;
  logic signed [SUM_W-1:0]   sat;
  logic                      v1, v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_reg  <= DIM_CFG_W'(MAX_ROWS);
      cols_reg  <= DIM_CFG_W'(MAX_COLS);
      chans_reg <= CNT_CFG_W'(MAX_CHANNELS);
      filts_reg <= CNT_CFG_W'(MAX_FILTERS);
    end else if (write_enable) begin
      unique case (cfg_reg_t'(reg_index))
        REG_ROWS:  rows_reg  <= write_data[DIM_CFG_W-1:0];
        REG_COLS:  cols_reg  <= write_data[DIM_CFG_W-1:0];
        REG_CHANS: chans_reg <= write_data[CNT_CFG_W-1:0];
        REG_FILTS: filts_reg <= write_data[CNT_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // oversized settings act as the store limit
  assign rows_eff  = (rows_reg  > DIM_CFG_W'(MAX_ROWS))     ? DIM_CFG_W'(MAX_ROWS)     : rows_reg;
  assign cols_eff  = (cols_reg  > DIM_CFG_W'(MAX_COLS))     ? DIM_CFG_W'(MAX_COLS)     : cols_reg;
  assign chans_eff = (chans_reg > CNT_CFG_W'(MAX_CHANNELS)) ? CNT_CFG_W'(MAX_CHANNELS) : chans_reg;
  assign filts_eff = (filts_reg > CNT_CFG_W'(MAX_FILTERS))  ? CNT_CFG_W'(MAX_FILTERS)  : filts_reg;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      q_row    <= row;
      q_col    <= col;
      q_filter <= filter;
    end
  end

  assign stat.chans     = chans_eff;
  assign stat.range_err = ((DIM_CFG_W'(q_row) + DIM_CFG_W'(1)) >= rows_eff) ||
                          ((DIM_CFG_W'(q_col) + DIM_CFG_W'(1)) >= cols_eff) ||
                          (CNT_CFG_W'(q_filter) >= filts_eff);

  // tap bit 1 is the kernel row, bit 0 the kernel column
  assign rd_row    = q_row + ROW_W'(cmd.tap[1]);
  assign rd_col    = q_col + COL_W'(cmd.tap[0]);
  assign w_wr_addr = {filter, channel, tap};
  assign a_wr_addr = {row, col, channel};
  assign w_rd_addr = {q_filter, cmd.ch, cmd.tap};
  assign a_rd_addr = {rd_row, rd_col, cmd.ch};

  always_ff @(posedge clk) begin
    if (cmd.wr_weight) begin
      wmem[w_wr_addr] <= value;
    end
    if (cmd.issue) begin
      rd_w <= wmem[w_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_act) begin
      amem[a_wr_addr] <= value;
    end
    if (cmd.issue) begin
      rd_a <= amem[a_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      prod <= rd_a * rd_w;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  // floor shift, then clamp to the signed 32-bit range
  assign shifted = acc >>> FRAC_SHIFT;
  always_comb begin
    priority if (shifted > SAT_MAX) begin
      sat = SAT_MAX[SUM_W-1:0];
    end else if (shifted < SAT_MIN) begin
      sat = SAT_MIN[SUM_W-1:0];
    end else begin
      sat = shifted[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_of_range <= stat.range_err;
      sum          <= stat.range_err ? '0 : sat;
    end
  end

  a_range_gives_zero: assert property (@(posedge clk) disable iff (rst)
    (done && out_of_range) |-> (sum == '0))
    else $error("c2d_dp: out-of-range result carries a nonzero sum");

  a_product_follows_read: assert property (@(posedge clk) disable iff (rst)
    v2 |-> $past(v1))
    else $error("c2d_dp: accumulate without a preceding memory read");

  a_no_mac_at_load: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!v1 && !v2))
    else $error("c2d_dp: result loaded while products still in flight");

endmodule

/* sv/conv2d_2x2_multichannel.sv */
// conv2d_2x2_multichannel: top level of the valid 2x2 multi-channel convolution block.
// Depends on c2d_pkg, c2d_ctrl and c2d_dp.

// A word is taken at a rising edge with start high and busy low. Weight and activation
// writes (command 0 and 1) complete at that edge, return no result and leave busy low, so
// one write per cycle is possible. Command 3 is taken and dropped. A query (command 2) holds
// busy high and returns one result on sum/out_of_range, marked by done for exactly one cycle;
// the receiver cannot hold it off, so capture it when done is high. For an in-range query,
// done follows a range check, the products for every tap of the C active channels, C being
// min(input_channels, 8), one channel/tap product per cycle from one shared multiplier fed
// from single-read-port weight and activation memories, and a drain of the three-stage
// read/multiply/accumulate pipeline. An out-of-range query skips the reads and answers
// with out_of_range set and sum zero. A new word is taken in the cycle done is high.
// The sum is the Q16.16 accumulation shifted right by 8 (floor) and clamped to 32 bits.
// Memories hold no reset value: read only entries already written. Write the configuration
// registers only while busy is low and no result is pending.
module conv2d_2x2_multichannel
  import c2d_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [CMD_W-1:0]           command,
  input  logic [ROW_W-1:0]           row,
  input  logic [COL_W-1:0]           col,
  input  logic [CH_W-1:0]            channel,
  input  logic [FILTER_W-1:0]        filter,
  input  logic [TAP_W-1:0]           tap,
  input  logic signed [VALUE_W-1:0]  value,
  input  logic                       write_enable,
  input  logic [CFG_IDX_W-1:0]       reg_index,
  input  logic [CFG_DATA_W-1:0]      write_data,
  output logic signed [SUM_W-1:0]    sum,
  output logic                       out_of_range,
  output logic                       done
);

  c2d_cmd_t  cmd;
  c2d_stat_t stat;

  // sequencer: decodes the command word and walks channels and taps
  c2d_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  // storage, multiply-accumulate and result registers
  c2d_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .row          (row),
    .col          (col),
    .channel      (channel),
    .filter       (filter),
    .tap          (tap),
    .value        (value),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .sum          (sum),
    .out_of_range (out_of_range),
    .done         (done)
  );

endmodule
